// File: src/smd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_pkg
// Types and constants shared by the sign-magnitude divider.
// ----------------------------------------------------------------------------
package smd_pkg;

	localparam int MAG_BITS  = 15;
	localparam int FRAC_BITS = 5;
	localparam int QUOT_BITS = MAG_BITS + FRAC_BITS;
	localparam int CNT_W     = $clog2(QUOT_BITS);

	typedef struct packed {
		logic [MAG_BITS-1:0] dividend_magnitude;
		logic                dividend_negative;
		logic [MAG_BITS-1:0] divisor_magnitude;
		logic                divisor_negative;
	} smd_in_t;

	typedef struct packed {
		logic [QUOT_BITS-1:0] quotient_magnitude;
		logic                 quotient_negative;
		logic                 divide_by_zero;
	} smd_out_t;

	// controls from the sequencer to the remainder unit
	typedef struct packed {
		logic load;  // new operands
		logic step;  // one quotient bit this cycle
		logic frac;  // step lies in the fraction part
	} smd_ctl_t;

endpackage

// File: src/smd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_cell
// One bit of the dividend/quotient chain: loads, or takes its neighbor's bit.
// ----------------------------------------------------------------------------
module smd_cell (
	input  logic clk,
	input  logic load,
	input  logic load_bit,
	input  logic shift,
	input  logic shift_in,
	output logic q
);

	logic q_q;

	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= load_bit;
		end else if (shift) begin
			q_q <= shift_in;
		end
	end

	assign q = q_q;

endmodule

// File: src/smd_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_rem
// Partial remainder register with compare/subtract; yields one quotient bit.
// ----------------------------------------------------------------------------
module smd_rem (
	input  logic                         clk,
	input  smd_pkg::smd_ctl_t            ctl,
	input  logic [smd_pkg::MAG_BITS-1:0] divisor,
	input  logic                         in_bit,
	output logic                         qbit
);

	logic [smd_pkg::MAG_BITS-1:0] rem_q;
	logic [smd_pkg::MAG_BITS-1:0] den_q;
	logic                         seen_q;   // a dividend one has entered
	logic [smd_pkg::MAG_BITS:0]   shifted;
	logic [smd_pkg::MAG_BITS:0]   diff;
	logic                         ge;
	logic                         den_zero;

	assign shifted  = {rem_q, in_bit};
	assign diff     = shifted - {1'b0, den_q};
	assign ge       = shifted >= {1'b0, den_q};
	assign den_zero = (den_q == '0);

	// zero divisor: ones from the dividend's leading one onward, and in every fraction step
	assign qbit = den_zero ? (seen_q | in_bit | ctl.frac) : ge;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= '0;
			den_q  <= divisor;
			seen_q <= 1'b0;
		end else if (ctl.step) begin
			rem_q  <= ge ? diff[smd_pkg::MAG_BITS-1:0] : shifted[smd_pkg::MAG_BITS-1:0];
			seen_q <= seen_q | in_bit;
		end
	end

endmodule

// File: src/sign_magnitude_fixed_point_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_point_divider
// Restoring divider for sign-magnitude operands, Q15.5 quotient magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the beat is taken at the edge where start
//   is high and busy is low. busy then stays high while the quotient is
//   formed, one bit per cycle over 15 integer and 5 fraction steps.
//   The result beat sits on result for exactly one cycle with done high;
//   done is registered and rises after the last quotient step. The
//   receiver cannot stall it.
//   busy is already low in the done cycle, so the next start may coincide
//   with done; no new item is taken while a quotient is being formed.
//   The rate is set by the single compare/subtract in smd_rem, used once per
//   quotient bit, while the bit chain of smd_cell shifts one place a cycle:
//   dividend bits leave its head, quotient bits enter at its tail.
//   Divisor zero: divide_by_zero is set and the magnitude is ones in the low
//   (bit length of dividend + 5) bits. The sign is always the XOR of the
//   input signs, negative zero included.
//   Reset (arst_n low) drops busy and done at once; no item is pending.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_point_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  smd_pkg::smd_in_t  request,
	output logic              busy,
	output logic              done,
	output smd_pkg::smd_out_t result
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                    state_q;
	logic [smd_pkg::CNT_W-1:0] cnt_q;
	logic                      done_q;
	logic                      sign_q;
	logic                      dz_q;

	logic                         accept;
	smd_pkg::smd_ctl_t            ctl;
	logic                         qbit;
	logic [smd_pkg::QUOT_BITS-1:0] chain;

	assign accept   = start && (state_q == ST_IDLE);
	assign ctl.load = accept;
	assign ctl.step = (state_q == ST_RUN);
	assign ctl.frac = (cnt_q >= smd_pkg::CNT_W'(smd_pkg::MAG_BITS));

	// sequencer: counts quotient steps, strobes done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + smd_pkg::CNT_W'(1);
					if (cnt_q == smd_pkg::CNT_W'(smd_pkg::QUOT_BITS - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sign and zero-divisor flag, captured with the operands
	always_ff @(posedge clk) begin
		if (accept) begin
			sign_q <= request.dividend_negative ^ request.divisor_negative;
			dz_q   <= (request.divisor_magnitude == '0);
		end
	end

	// bit chain: cell QUOT_BITS-1 is the head, fraction cells load zeros
	for (genvar i = 0; i < smd_pkg::QUOT_BITS; i++) begin : g_chain
		logic load_bit;
		logic shift_in;

		if (i >= smd_pkg::FRAC_BITS) begin : g_int
			assign load_bit = request.dividend_magnitude[i - smd_pkg::FRAC_BITS];
		end else begin : g_frac
			assign load_bit = 1'b0;
		end

		if (i == 0) begin : g_tail
			assign shift_in = qbit;
		end else begin : g_body
			assign shift_in = chain[i-1];
		end

		smd_cell u_cell (
			.clk      (clk),
			.load     (ctl.load),
			.load_bit (load_bit),
			.shift    (ctl.step),
			.shift_in (shift_in),
			.q        (chain[i])
		);
	end

	smd_rem u_rem (
		.clk     (clk),
		.ctl     (ctl),
		.divisor (request.divisor_magnitude),
		.in_bit  (chain[smd_pkg::QUOT_BITS-1]),
		.qbit    (qbit)
	);

	assign busy                      = (state_q != ST_IDLE);
	assign done                      = done_q;
	assign result.quotient_magnitude = chain;
	assign result.quotient_negative  = sign_q;
	assign result.divide_by_zero     = dz_q;

	// an accepted beat always starts a run
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && (cnt_q == '0))
		else $error("accepted beat did not start a run");

	// done follows only the last quotient step
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RUN)
			&& ($past(cnt_q) == smd_pkg::CNT_W'(smd_pkg::QUOT_BITS - 1)))
		else $error("done without a finished run");

	// step counter stays within the quotient length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q < smd_pkg::CNT_W'(smd_pkg::QUOT_BITS)))
		else $error("step counter out of range");

	// zero divisor always gives ones in the fraction bits
	a_dz_frac_ones: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero
			|-> (&result.quotient_magnitude[smd_pkg::FRAC_BITS-1:0]))
		else $error("zero divisor pattern broken");

	// the result beat never overlaps a run
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

endmodule
